### hdl/base64_stream_decoder_unit_defines.svh
// Assertion macros shared by the base64 stream decoder RTL.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define B64D_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define B64D_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define B64D_ASSERT_IMP(label, clk, rst, ante, cons)
`define B64D_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/b64d_pkg.sv
// Types, codes and the character table of the base64 stream decoder.
package b64d_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_END
   } state_type;

   typedef enum logic [2:0] {
      STAT_DATA     = 3'd0,
      STAT_OK       = 3'd1,
      STAT_NULL     = 3'd2,
      STAT_DANGLE   = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Result of merging one sextet into the byte assembly.
   typedef struct packed {
      logic       produces;
      logic [7:0] out_byte;
      logic [5:0] held_next;
      logic [1:0] pos_next;
   } feed_result_type;

   // Both alphabets map here; anything unknown is sextet zero.
   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] sx;
      sx = 6'd0;
      if (c inside {[8'h41:8'h5A]}) begin
         sx = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         sx = 6'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         sx = 6'(c - 8'h30 + 8'd52);
      end else if (c inside {8'h2B, 8'h2D, 8'h2E}) begin
         sx = 6'd62;
      end else if (c inside {8'h2C, 8'h2F, 8'h5F}) begin
         sx = 6'd63;
      end
      return sx;
   endfunction

endpackage

### hdl/b64d_feed.sv
// Shared sextet merge unit: folds one sextet into the partial byte.
module b64d_feed
   import b64d_pkg::*;
(
   input  logic [1:0]      pos,
   input  logic [5:0]      held,
   input  logic [5:0]      sextet,
   output feed_result_type result
);

   always_comb begin
      result = '0;
      case (pos)
         2'd0: begin
            result.held_next = sextet;
            result.pos_next  = 2'd1;
         end
         2'd1: begin
            result.produces  = 1'b1;
            result.out_byte  = {held, sextet[5:4]};
            result.held_next = {2'b00, sextet[3:0]};
            result.pos_next  = 2'd2;
         end
         2'd2: begin
            result.produces  = 1'b1;
            result.out_byte  = {held[3:0], sextet[5:2]};
            result.held_next = {4'b0000, sextet[1:0]};
            result.pos_next  = 2'd3;
         end
         default: begin
            result.produces  = 1'b1;
            result.out_byte  = {held[1:0], sextet};
            result.held_next = 6'd0;
            result.pos_next  = 2'd0;
         end
      endcase
   end

endmodule

### hdl/base64_stream_decoder_unit.sv
// Base64 stream decoder top level: one character per item in, bytes and end status out.
// An item is taken in ST_IDLE; the shared sextet unit then merges each held '=' as a zero sextet
// and then the character itself in ST_FEED, and the end of a string adds a pass through ST_END.
// A new item is taken only once the previous one has been fully processed, back in ST_IDLE.
// Results are registered; a stalled result holds the sequencer.
// Synchronous active-high reset clears the sequencer, the decode state and the result valid.
`include "base64_stream_decoder_unit_defines.svh"

module base64_stream_decoder_unit
   import b64d_pkg::*;
#(
   parameter int PAD_RUN_MAX = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_char
   input  logic       req_tlast,   // is_last
   input  logic       req_tuser,   // [0] is_empty
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_run
   output logic [2:0] rsp_tuser    // [2:0] status
);

   localparam int PW = $clog2(PAD_RUN_MAX + 1);
   localparam int FW = $clog2(PAD_RUN_MAX + 2);

   state_type       state_ff, state_in;
   logic [1:0]      pos_ff, pos_in;
   logic [5:0]      held_ff, held_in;
   logic [PW-1:0]   pad_ff, pad_in;
   logic            err_ff, err_in;
   logic [FW-1:0]   feeds_ff, feeds_in;
   logic [5:0]      sx_ff, sx_in;
   logic            last_ff, last_in;
   logic            empty_ff, empty_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   status_type      rsp_stat_ff, rsp_stat_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            accept;
   logic            slot_free;
   logic [5:0]      feed_sx;
   logic [FW-1:0]   rem;
   logic            more;
   feed_result_type fr;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Held pads go in as zero sextets; the character sextet is the final feed.
   assign feed_sx = (feeds_ff == FW'(1)) ? sx_ff : 6'd0;
   assign rem     = feeds_ff - FW'(1);
   assign more    = last_ff || (rem >= FW'(2)) ||
                    ((rem == FW'(1)) && (fr.pos_next != 2'd0));

   b64d_feed u_feed (
      .pos    (pos_ff),
      .held   (held_ff),
      .sextet (feed_sx),
      .result (fr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         held_ff      <= '0;
         pad_ff       <= '0;
         err_ff       <= 1'b0;
         feeds_ff     <= '0;
         last_ff      <= 1'b0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         held_ff      <= held_in;
         pad_ff       <= pad_in;
         err_ff       <= err_in;
         feeds_ff     <= feeds_in;
         last_ff      <= last_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff       <= sx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      held_in      = held_ff;
      pad_in       = pad_ff;
      err_in       = err_ff;
      feeds_in     = feeds_ff;
      sx_in        = sx_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in  = req_tlast;
               empty_in = req_tuser;
               feeds_in = '0;
               sx_in    = 6'd0;
               if (!req_tuser) begin
                  if (req_tdata == PAD_CHAR) begin
                     if (pad_ff >= PW'(PAD_RUN_MAX)) begin
                        // Run too long: the oldest held pad becomes a zero sextet.
                        err_in   = 1'b1;
                        feeds_in = FW'(1);
                     end else begin
                        pad_in = pad_ff + PW'(1);
                     end
                  end else begin
                     feeds_in = FW'(pad_ff) + FW'(1);
                     sx_in    = sextet_of(req_tdata);
                     pad_in   = '0;
                  end
               end
               if (!req_tuser && (feeds_in != '0)) begin
                  state_in = ST_FEED;
               end else if (req_tuser || req_tlast) begin
                  state_in = ST_END;
               end
            end
         end
         ST_FEED: begin
            if (slot_free) begin
               pos_in   = fr.pos_next;
               held_in  = fr.held_next;
               feeds_in = rem;
               if (fr.produces) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = fr.out_byte;
                  rsp_stat_in  = STAT_DATA;
                  rsp_last_in  = !more;
               end
               if (rem == '0) begin
                  state_in = last_ff ? ST_END : ST_IDLE;
               end
            end
         end
         ST_END: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'd0;
               rsp_last_in  = 1'b1;
               if (empty_ff) begin
                  rsp_stat_in = STAT_NULL;
               end else if (err_ff) begin
                  rsp_stat_in = STAT_OVERFLOW;
               end else if (pos_ff == 2'd1) begin
                  rsp_stat_in = STAT_DANGLE;
               end else begin
                  rsp_stat_in = STAT_OK;
               end
               // The string is over: held pads are dropped as trailing.
               pos_in   = '0;
               held_in  = '0;
               pad_in   = '0;
               err_in   = 1'b0;
               feeds_in = '0;
               last_in  = 1'b0;
               empty_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

   `B64D_ASSERT_IMP(a_idle_no_feeds, clock, reset, state_ff == ST_IDLE, feeds_ff == '0)
   `B64D_ASSERT_IMP(a_pad_bounded, clock, reset, 1'b1, pad_ff <= PW'(PAD_RUN_MAX))
   `B64D_ASSERT_IMP(a_end_is_last, clock, reset,
                    rsp_valid_ff && (rsp_stat_ff != STAT_DATA), rsp_last_ff)
   `B64D_ASSERT_NXT(a_empty_ends, clock, reset, accept && req_tuser, state_ff == ST_END)
   `B64D_ASSERT_IMP(a_feed_nonzero, clock, reset, state_ff == ST_FEED, feeds_ff != '0)

endmodule

### test/base64_stream_decoder_unit_tb.sv
// Self-checking testbench for the base64 stream decoder: directed strings, then random ones.
`timescale 1ns / 1ps

module base64_stream_decoder_unit_tb
   import b64d_pkg::*;
;
   localparam int PAD_MAX        = 4;
   localparam int RANDOM_ITEMS   = 330;
   localparam int WATCHDOG_LIMIT = 4000;

   class b64_scoreboard;
      typedef struct {
         logic [7:0] data;
         status_type status;
         bit         last;
      } decoded_item_type;

      decoded_item_type expected_q[$];
      logic [1:0]       group_pos;
      logic [5:0]       carry_bits;
      int unsigned      held_pads;
      bit               pad_overflow;
      int               errors;

      function new();
         clear_string();
         errors = 0;
      endfunction

      function void clear_string();
         group_pos    = 2'd0;
         carry_bits   = 6'd0;
         held_pads    = 0;
         pad_overflow = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [5:0] char_to_sextet(logic [7:0] c);
         if (c >= "A" && c <= "Z") return 6'(c - 8'd65);
         if (c >= "a" && c <= "z") return 6'(c - 8'd97 + 8'd26);
         if (c >= "0" && c <= "9") return 6'(c - 8'd48 + 8'd52);
         if (c == "+" || c == "-" || c == ".") return 6'd62;
         if (c == "," || c == "/" || c == "_") return 6'd63;
         return 6'd0;
      endfunction

      // Merges one sextet into the byte being assembled; a byte is due on every
      // position but the first.
      function void merge_sextet(logic [5:0] sx, output bit produced, output logic [7:0] b);
         produced = 1'b1;
         b = 8'd0;
         case (group_pos)
            2'd0: begin
               carry_bits = sx;
               produced   = 1'b0;
            end
            2'd1: begin
               b          = {carry_bits, sx[5:4]};
               carry_bits = {2'b00, sx[3:0]};
            end
            2'd2: begin
               b          = {carry_bits[3:0], sx[5:2]};
               carry_bits = {4'd0, sx[1:0]};
            end
            default: begin
               b          = {carry_bits[1:0], sx};
               carry_bits = 6'd0;
            end
         endcase
         group_pos = group_pos + 2'd1;
      endfunction

      function void note_input(logic [7:0] ch, bit last, bit empty);
         decoded_item_type run[$];
         bit               produced;
         logic [7:0]       b;
         status_type       st;
         if (empty) begin
            clear_string();
            run.push_back('{8'h00, STAT_NULL, 1'b0});
         end else begin
            if (ch == PAD_CHAR) begin
               if (held_pads >= PAD_MAX) begin
                  // The oldest held pad is released as data so the count stays at the limit.
                  pad_overflow = 1'b1;
                  merge_sextet(6'd0, produced, b);
                  if (produced) run.push_back('{b, STAT_DATA, 1'b0});
               end else begin
                  held_pads++;
               end
            end else begin
               while (held_pads > 0) begin
                  merge_sextet(6'd0, produced, b);
                  if (produced) run.push_back('{b, STAT_DATA, 1'b0});
                  held_pads--;
               end
               merge_sextet(char_to_sextet(ch), produced, b);
               if (produced) run.push_back('{b, STAT_DATA, 1'b0});
            end
            if (last) begin
               if (pad_overflow) st = STAT_OVERFLOW;
               else if (group_pos == 2'd1) st = STAT_DANGLE;
               else st = STAT_OK;
               run.push_back('{8'h00, st, 1'b0});
               clear_string();
            end
         end
         if (run.size() > 0) run[run.size() - 1].last = 1'b1;
         foreach (run[i]) expected_q.push_back(run[i]);
      endfunction

      function void check_result(logic [7:0] data, logic [2:0] status, logic last);
         decoded_item_type exp;
         if (expected_q.size() == 0) begin
            $error("unexpected result: out_byte %h status %0d last_of_run %0d",
                   data, status, last);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, status);
            errors++;
         end
         if (data !== exp.data) begin
            $error("out_byte: expected %h, actual %h", exp.data, data);
            errors++;
         end
         if (last !== exp.last) begin
            $error("last_of_run: expected %0d, actual %0d", exp.last, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       req_tuser  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [2:0] rsp_tuser;

   int tx_idle_pct = 17;
   int rx_idle_pct = 88;
   int items_sent  = 0;
   int directed_items;

   string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-.,/_";

   b64_scoreboard sb;

   base64_stream_decoder_unit #(
      .PAD_RUN_MAX(PAD_MAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Ends the run if neither channel moves an item for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Called and returns at a falling edge.
   task automatic send_item(input logic [7:0] ch, input bit last, input bit empty);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      req_tuser  <= empty;
      do @(posedge clock); while (!req_tready);
      sb.note_input(ch, last, empty);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit last_at_end);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], last_at_end && (i == s.len() - 1), 1'b0);
      end
   endtask

   // Mostly well-formed strings with embedded pad runs, some noise, some aborted strings and some lone empty markers.
   task automatic send_random_string();
      logic [7:0] chars[$];
      int         n;
      int         kind;
      bit         abort;
      if ($urandom_range(0, 19) == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         return;
      end
      n = $urandom_range(1, 14);
      while (chars.size() < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            chars.push_back(b64_alphabet[$urandom_range(0, b64_alphabet.len() - 1)]);
         end else if (kind < 88) begin
            repeat ($urandom_range(1, PAD_MAX + 3)) chars.push_back(PAD_CHAR);
         end else begin
            chars.push_back(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, PAD_MAX + 2)) chars.push_back(PAD_CHAR);
      end
      abort = ($urandom_range(0, 11) == 0);
      foreach (chars[i]) send_item(chars[i], !abort && (i == chars.size() - 1), 1'b0);
      if (abort) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item("x", 1'b0, 1'b1);
      send_text("TWFu", 1'b1);
      send_text("-.,_", 1'b1);
      send_text("+/8=", 1'b1);
      send_text("Q", 1'b1);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_text("==", 1'b1);
      // Pad run one past the limit, then data: held pads become zero sextets.
      send_text("=====B", 1'b1);
      // A string cut short by an empty marker that also carries the last flag.
      send_text("AB", 1'b0);
      send_item("C", 1'b1, 1'b1);
      directed_items = items_sent;

      while (items_sent < directed_items + RANDOM_ITEMS / 3) send_random_string();
      tx_idle_pct = 88;
      rx_idle_pct = 17;
      while (items_sent < directed_items + 2 * RANDOM_ITEMS / 3) send_random_string();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (items_sent < directed_items + RANDOM_ITEMS) send_random_string();
      req_tvalid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
